[rtl/qfd_pkg.sv]
// Shared constants and types for the quadrature FM discriminator.
// No dependencies; imported by every module of the block.
package qfd_pkg;

    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int FIELD_W          = 16;
    localparam int GAIN_W           = 16;
    localparam int QUO_W            = 17;
    localparam int FRAC_W           = 16;
    localparam int OP_W             = 19;
    localparam int PROD_W           = 2 * OP_W;
    localparam int PHASE_W          = 17;
    localparam int GAIN_SHIFT       = 8;
    localparam int PHASE_SHIFT      = 3;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd256;

    localparam logic signed [OP_W-1:0] COEF_C3 = -19'sd3047;
    localparam logic signed [OP_W-1:0] COEF_C2 = 19'sd10441;
    localparam logic signed [OP_W-1:0] COEF_C1 = 19'sd21471;

    localparam logic signed [PHASE_W-1:0] PIBY2_Q13 = 17'sd12868;
    localparam logic signed [PHASE_W-1:0] PI_Q13    = 17'sd25736;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam int REG_W   = PADDR_W - 2;
    localparam logic [REG_W-1:0] REG_GAIN = 1'b0;

    typedef struct packed {
        logic zero;
        logic swap;
        logic neg_re;
        logic neg_im;
    } t_fold;

endpackage

[rtl/quadrature_fm_discriminator.sv]
// Quadrature FM discriminator top level: stream ports, gain register, sequencer.
// Depends on qfd_pkg, qfd_cmul, qfd_div and qfd_poly.
//
// Usage: complex samples enter on the s_axis channel (in_i low half, in_q high
// half of tdata); one frequency word per sample leaves on m_axis. The gain
// register (unsigned Q8.8) sits at APB address 0; the user must write it only
// while idle, which the block itself does not enforce. The first sample after
// reset only primes the stored sample and returns 0 through the S_OUT state.
// Each later sample passes from its transfer through the bit-serial complex
// multiplier, the restoring divider (one quotient bit per cycle) and the
// polynomial unit, with registered handoffs between the units. A zero product
// skips the divider. One sample is in work at a time; s_axis_tready is high
// only while the sequencer is idle.
// A finished result waits in the output register; if the receiver stalls with
// that register full, the next result is held and no new sample is taken.
// Reset clears the stored sample, the primed flag, valid flags and sets gain
// to 1.0.
module quadrature_fm_discriminator #(
    parameter int SAMPLE_WIDTH = qfd_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [2*qfd_pkg::FIELD_W-1:0]  s_axis_tdata,   // [15:0] in_i, [31:16] in_q
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [qfd_pkg::FIELD_W-1:0]    m_axis_tdata,   // [15:0] freq
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [qfd_pkg::PADDR_W-1:0]    paddr,
    input  logic [qfd_pkg::PDATA_W-1:0]    pwdata,
    output logic [qfd_pkg::PDATA_W-1:0]    prdata,
    output logic                           pready
);
    import qfd_pkg::*;

    localparam int SW = SAMPLE_WIDTH;
    localparam int AW = 2 * SW + 1;
    localparam int MW = 2 * SW;
    localparam int XW = (SW > FIELD_W) ? SW : FIELD_W;

    typedef enum logic [2:0] {S_IDLE, S_MUL, S_DIV, S_POLY, S_OUT} t_state;

    t_state                    r_state;
    logic                      r_primed;
    logic signed [SW-1:0]      r_prev_i;
    logic signed [SW-1:0]      r_prev_q;
    logic signed [SW-1:0]      r_cur_i;
    logic signed [SW-1:0]      r_cur_q;
    logic                      r_mul_start;
    logic                      r_div_start;
    logic                      r_poly_start;
    logic [MW-1:0]             r_num;
    logic [MW-1:0]             r_den;
    t_fold                     r_fold;
    logic [QUO_W-1:0]          r_a;
    logic [FIELD_W-1:0]        r_res;
    logic                      r_out_valid;
    logic [FIELD_W-1:0]        r_out_data;
    logic [GAIN_W-1:0]         r_gain;

    logic [XW-1:0]             w_ext_i;
    logic [XW-1:0]             w_ext_q;
    logic                      w_in_xfer;
    logic                      w_mul_done;
    logic signed [AW-1:0]      w_re;
    logic signed [AW-1:0]      w_im;
    logic signed [AW-1:0]      w_abs_re;
    logic signed [AW-1:0]      w_abs_im;
    logic [MW-1:0]             w_ax;
    logic [MW-1:0]             w_ay;
    logic                      w_swap;
    logic [MW-1:0]             w_mn;
    logic [MW-1:0]             w_mx;
    t_fold                     w_fold;
    logic                      w_div_done;
    logic [QUO_W-1:0]          w_quo;
    logic                      w_poly_done;
    logic signed [FIELD_W-1:0] w_freq;
    logic                      w_cfg_wr;

    // configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready &&
                      (paddr[PADDR_W-1:2] == REG_GAIN);
    assign prdata   = (paddr[PADDR_W-1:2] == REG_GAIN) ? PDATA_W'(r_gain) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GAIN_RESET;
        end else if (w_cfg_wr) begin
            r_gain <= pwdata[GAIN_W-1:0];
        end
    end

    // sample is the low SW bits of each field
    assign w_ext_i = XW'(s_axis_tdata[FIELD_W-1:0]);
    assign w_ext_q = XW'(s_axis_tdata[2*FIELD_W-1:FIELD_W]);

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_xfer     = s_axis_tvalid && s_axis_tready;

    qfd_cmul #(.SW(SW)) u_cmul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_mul_start),
        .i_cur_i  (r_cur_i),
        .i_cur_q  (r_cur_q),
        .i_prev_i (r_prev_i),
        .i_prev_q (r_prev_q),
        .o_done   (w_mul_done),
        .o_re     (w_re),
        .o_im     (w_im)
    );

    assign w_abs_re   = w_re[AW-1] ? -w_re : w_re;
    assign w_abs_im   = w_im[AW-1] ? -w_im : w_im;
    assign w_ax       = w_abs_re[MW-1:0];
    assign w_ay       = w_abs_im[MW-1:0];
    assign w_swap     = (w_ay > w_ax);
    assign w_mn       = w_swap ? w_ax : w_ay;
    assign w_mx       = w_swap ? w_ay : w_ax;
    assign w_fold     = '{zero: (w_mx == '0), swap: w_swap,
                          neg_re: w_re[AW-1], neg_im: w_im[AW-1]};

    qfd_div #(.MW(MW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    qfd_poly u_poly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_poly_start),
        .i_a     (r_a),
        .i_fold  (r_fold),
        .i_gain  (r_gain),
        .o_done  (w_poly_done),
        .o_freq  (w_freq)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_primed     <= 1'b0;
            r_prev_i     <= '0;
            r_prev_q     <= '0;
            r_mul_start  <= 1'b0;
            r_div_start  <= 1'b0;
            r_poly_start <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_mul_start  <= 1'b0;
            r_div_start  <= 1'b0;
            r_poly_start <= 1'b0;
            if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_xfer) begin
                        r_cur_i <= $signed(w_ext_i[SW-1:0]);
                        r_cur_q <= $signed(w_ext_q[SW-1:0]);
                        if (!r_primed) begin
                            r_prev_i <= $signed(w_ext_i[SW-1:0]);
                            r_prev_q <= $signed(w_ext_q[SW-1:0]);
                            r_primed <= 1'b1;
                            r_res    <= '0;
                            r_state  <= S_OUT;
                        end else begin
                            r_mul_start <= 1'b1;
                            r_state     <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    if (w_mul_done) begin
                        r_num    <= w_mn;
                        r_den    <= w_mx;
                        r_fold   <= w_fold;
                        r_prev_i <= r_cur_i;
                        r_prev_q <= r_cur_q;
                        if (w_fold.zero) begin
                            r_a          <= '0;
                            r_poly_start <= 1'b1;
                            r_state      <= S_POLY;
                        end else begin
                            r_div_start <= 1'b1;
                            r_state     <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_a          <= w_quo;
                        r_poly_start <= 1'b1;
                        r_state      <= S_POLY;
                    end
                end
                S_POLY: begin
                    if (w_poly_done) begin
                        r_res   <= w_freq;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= r_res;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

[rtl/qfd_cmul.sv]
// Bit-serial conjugate product cur*conj(prev) as re and im, one multiplier bit per cycle.
// Depends on qfd_pkg for the default sample width.
module qfd_cmul #(
    parameter int SW = qfd_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [SW-1:0] i_cur_i,
    input  logic signed [SW-1:0] i_cur_q,
    input  logic signed [SW-1:0] i_prev_i,
    input  logic signed [SW-1:0] i_prev_q,
    output logic                 o_done,
    output logic signed [2*SW:0] o_re,
    output logic signed [2*SW:0] o_im
);
    localparam int AW = 2 * SW + 1;
    localparam int CW = $clog2(SW);

    logic                 r_busy;
    logic                 r_done;
    logic [CW-1:0]        r_cnt;
    logic [SW-1:0]        r_sh_i;
    logic [SW-1:0]        r_sh_q;
    logic signed [AW-1:0] r_acc_re;
    logic signed [AW-1:0] r_acc_im;
    logic signed [AW-1:0] w_pi;
    logic signed [AW-1:0] w_pq;
    logic signed [AW-1:0] w_term_re;
    logic signed [AW-1:0] w_term_im;
    logic signed [AW-1:0] n_acc_re;
    logic signed [AW-1:0] n_acc_im;
    logic                 w_msb;

    assign w_pi      = AW'(i_prev_i);
    assign w_pq      = AW'(i_prev_q);
    assign w_msb     = (r_cnt == '0);
    assign w_term_re = (r_sh_i[SW-1] ? w_pi : '0) + (r_sh_q[SW-1] ? w_pq : '0);
    assign w_term_im = (r_sh_q[SW-1] ? w_pi : '0) - (r_sh_i[SW-1] ? w_pq : '0);
    // MSB first; the sign bit carries negative weight
    assign n_acc_re  = (r_acc_re <<< 1) + (w_msb ? -w_term_re : w_term_re);
    assign n_acc_im  = (r_acc_im <<< 1) + (w_msb ? -w_term_im : w_term_im);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy   <= 1'b1;
                r_cnt    <= '0;
                r_sh_i   <= i_cur_i;
                r_sh_q   <= i_cur_q;
                r_acc_re <= '0;
                r_acc_im <= '0;
            end else if (r_busy) begin
                r_acc_re <= n_acc_re;
                r_acc_im <= n_acc_im;
                r_sh_i   <= {r_sh_i[SW-2:0], 1'b0};
                r_sh_q   <= {r_sh_q[SW-2:0], 1'b0};
                r_cnt    <= r_cnt + 1'b1;
                if (r_cnt == CW'(SW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_re   = r_acc_re;
    assign o_im   = r_acc_im;

endmodule

[rtl/qfd_div.sv]
// Restoring divider, one quotient bit per cycle: quo = floor(num * 2^16 / den).
// Expects num <= den, den nonzero. Depends on qfd_pkg.
module qfd_div #(
    parameter int MW = 2 * qfd_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [MW-1:0]              i_num,
    input  logic [MW-1:0]              i_den,
    output logic                       o_done,
    output logic [qfd_pkg::QUO_W-1:0]  o_quo
);
    import qfd_pkg::*;

    localparam int CW = $clog2(QUO_W);

    logic            r_busy;
    logic            r_done;
    logic [CW-1:0]   r_cnt;
    logic [MW:0]     r_rem;
    logic [MW-1:0]   r_den;
    logic [QUO_W-1:0] r_quo;
    logic [MW+1:0]   w_diff;
    logic            w_ge;
    logic [MW:0]     w_rest;

    assign w_diff = {1'b0, r_rem} - {2'b00, r_den};
    assign w_ge   = !w_diff[MW+1];
    assign w_rest = w_ge ? w_diff[MW:0] : r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= {1'b0, i_num};
                r_den  <= i_den;
                r_quo  <= '0;
            end else if (r_busy) begin
                r_rem <= {w_rest[MW-1:0], 1'b0};
                r_quo <= {r_quo[QUO_W-2:0], w_ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(QUO_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

[rtl/qfd_poly.sv]
// Cubic arctangent polynomial, octant fold and gain scaling on one shared multiplier.
// Depends on qfd_pkg for coefficients and the fold flags.
module qfd_poly (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [qfd_pkg::QUO_W-1:0]          i_a,
    input  qfd_pkg::t_fold                     i_fold,
    input  logic [qfd_pkg::GAIN_W-1:0]         i_gain,
    output logic                               o_done,
    output logic signed [qfd_pkg::FIELD_W-1:0] o_freq
);
    import qfd_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SQ, ST_T1, ST_T2, ST_T3, ST_T4, ST_FOLD, ST_GAIN
    } t_state;

    localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(1) <<< (FRAC_W - 1);
    localparam logic signed [PROD_W-1:0] Y_MAX = (PROD_W'(1) <<< (FIELD_W - 1)) - PROD_W'(1);
    localparam logic signed [PROD_W-1:0] Y_MIN = -(PROD_W'(1) <<< (FIELD_W - 1));
    localparam logic signed [OP_W-1:0]   P_HALF = OP_W'(1) <<< (PHASE_SHIFT - 1);
    localparam logic signed [FIELD_W-1:0] F_MAX = {1'b0, {(FIELD_W-1){1'b1}}};
    localparam logic signed [FIELD_W-1:0] F_MIN = {1'b1, {(FIELD_W-1){1'b0}}};

    t_state                     r_state;
    logic                       r_done;
    logic [QUO_W-1:0]           r_a;
    t_fold                      r_fold;
    logic signed [OP_W-1:0]     r_s;
    logic signed [OP_W-1:0]     r_t;
    logic signed [PHASE_W-1:0]  r_p;
    logic signed [FIELD_W-1:0]  r_freq;

    logic signed [OP_W-1:0]     w_a_op;
    logic signed [OP_W-1:0]     w_x;
    logic signed [OP_W-1:0]     w_y;
    logic signed [PROD_W-1:0]   w_prod;
    logic signed [PROD_W-1:0]   w_rnd;
    logic signed [OP_W-1:0]     w_rnd_op;
    logic signed [OP_W-1:0]     w_r;
    logic signed [OP_W-1:0]     w_pr;
    logic signed [PHASE_W-1:0]  w_p1;
    logic signed [PHASE_W-1:0]  w_p2;
    logic signed [PHASE_W-1:0]  w_p3;
    logic signed [PHASE_W-1:0]  w_p;
    logic signed [PROD_W-1:0]   w_scaled;
    logic signed [FIELD_W-1:0]  w_sat;

    assign w_a_op = $signed(OP_W'(r_a));

    always_comb begin
        unique case (r_state)
            ST_SQ: begin
                w_x = w_a_op;
                w_y = w_a_op;
            end
            ST_T1: begin
                w_x = COEF_C3;
                w_y = r_s;
            end
            ST_T2, ST_T3: begin
                w_x = r_t;
                w_y = r_s;
            end
            ST_T4: begin
                w_x = r_t;
                w_y = w_a_op;
            end
            ST_GAIN: begin
                w_x = OP_W'(r_p);
                w_y = $signed(OP_W'(i_gain));
            end
            ST_IDLE, ST_FOLD: begin
                w_x = '0;
                w_y = '0;
            end
        endcase
    end

    assign w_prod   = w_x * w_y;
    assign w_rnd    = (w_prod + RND_HALF) >>> FRAC_W;
    assign w_rnd_op = w_rnd[OP_W-1:0];

    // phase in Q3.13 from the Q16 angle, then octant fold
    assign w_r  = r_t + w_a_op;
    assign w_pr = (w_r + P_HALF) >>> PHASE_SHIFT;
    assign w_p1 = r_fold.swap   ? PIBY2_Q13 - w_pr[PHASE_W-1:0] : w_pr[PHASE_W-1:0];
    assign w_p2 = r_fold.neg_re ? PI_Q13 - w_p1 : w_p1;
    assign w_p3 = r_fold.neg_im ? -w_p2 : w_p2;
    assign w_p  = r_fold.zero   ? '0 : w_p3;

    assign w_scaled = w_prod >>> GAIN_SHIFT;

    always_comb begin
        priority if (w_scaled > Y_MAX) begin
            w_sat = F_MAX;
        end else if (w_scaled < Y_MIN) begin
            w_sat = F_MIN;
        end else begin
            w_sat = w_scaled[FIELD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_a     <= i_a;
                        r_fold  <= i_fold;
                        r_state <= ST_SQ;
                    end
                end
                ST_SQ: begin
                    r_s     <= w_rnd_op;
                    r_state <= ST_T1;
                end
                ST_T1: begin
                    r_t     <= w_rnd_op + COEF_C2;
                    r_state <= ST_T2;
                end
                ST_T2: begin
                    r_t     <= w_rnd_op - COEF_C1;
                    r_state <= ST_T3;
                end
                ST_T3: begin
                    r_t     <= w_rnd_op;
                    r_state <= ST_T4;
                end
                ST_T4: begin
                    r_t     <= w_rnd_op;
                    r_state <= ST_FOLD;
                end
                ST_FOLD: begin
                    r_p     <= w_p;
                    r_state <= ST_GAIN;
                end
                ST_GAIN: begin
                    r_freq  <= w_sat;
                    r_done  <= 1'b1;
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_freq = r_freq;

endmodule

[test/qfd_freq_checker.sv]
// Checker for the quadrature FM discriminator: watches the sample, result and APB channels.
// Predicts each freq word from its own copy of gain and the stored sample; imports qfd_pkg.
`timescale 1ns / 1ps

module qfd_freq_checker
    import qfd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic [2*FIELD_W-1:0]  i_in_data,    // [15:0] in_i, [31:16] in_q
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic [FIELD_W-1:0]    i_out_data,   // [15:0] freq
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic                  i_pready,
    input  logic [PADDR_W-1:0]    i_paddr,
    input  logic [PDATA_W-1:0]    i_pwdata,
    input  logic [PDATA_W-1:0]    i_prdata,
    output int                    o_fail_count,
    output int                    o_pending
);

    logic [GAIN_W-1:0]          gain_q;
    logic signed [FIELD_W-1:0]  last_i;
    logic signed [FIELD_W-1:0]  last_q;
    logic                       have_prev;
    logic signed [FIELD_W-1:0]  samp_i;
    logic signed [FIELD_W-1:0]  samp_q;
    logic signed [FIELD_W-1:0]  due;
    logic signed [FIELD_W-1:0]  freq_due [$];

    function automatic longint round_shift(longint x, int n);
        return (x + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    // octant-folded cubic arctangent, Q3.13 radians
    function automatic longint angle_q13(longint re, longint im);
        longint ax, ay, mn, mx, a, s, t, p;
        ax = (re < 0) ? -re : re;
        ay = (im < 0) ? -im : im;
        mn = (ax < ay) ? ax : ay;
        mx = (ax < ay) ? ay : ax;
        if (mx == 0)
            return 0;
        a = (mn <<< FRAC_W) / mx;
        s = round_shift(a * a, FRAC_W);
        t = round_shift(longint'(COEF_C3) * s, FRAC_W) + longint'(COEF_C2);
        t = round_shift(t * s, FRAC_W) - longint'(COEF_C1);
        t = round_shift(t * s, FRAC_W);
        t = round_shift(t * a, FRAC_W);
        p = round_shift(a + t, PHASE_SHIFT);
        if (ay > ax)
            p = longint'(PIBY2_Q13) - p;
        if (re < 0)
            p = longint'(PI_Q13) - p;
        if (im < 0)
            p = -p;
        return p;
    endfunction

    function automatic logic signed [FIELD_W-1:0] freq_of(longint ci, longint cq,
                                                          longint pi, longint pq,
                                                          longint g);
        longint re, im, y;
        re = ci * pi + cq * pq;
        im = cq * pi - ci * pq;
        y = (angle_q13(re, im) * g) >>> GAIN_SHIFT;
        if (y > 32767)
            y = 32767;
        else if (y < -32768)
            y = -32768;
        return FIELD_W'(y);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            gain_q = GAIN_RESET;
            last_i = '0;
            last_q = '0;
            have_prev = 1'b0;
            freq_due.delete();
            o_fail_count = 0;
        end else begin
            // check before queuing, so a result never meets its own sample
            if (i_out_valid && i_out_ready) begin
                if (freq_due.size() == 0) begin
                    $display("%0t: freq transfer with nothing due, expected none, got %0d",
                             $time, $signed(i_out_data));
                    o_fail_count++;
                end else begin
                    due = freq_due.pop_front();
                    if (i_out_data !== due) begin
                        $display("%0t: freq mismatch, expected %0d, got %0d",
                                 $time, due, $signed(i_out_data));
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                samp_i = $signed(i_in_data[FIELD_W-1:0]);
                samp_q = $signed(i_in_data[2*FIELD_W-1:FIELD_W]);
                if (!have_prev)
                    due = '0;
                else
                    due = freq_of(samp_i, samp_q, last_i, last_q, longint'(gain_q));
                freq_due = {freq_due, due};
                last_i = samp_i;
                last_q = samp_q;
                have_prev = 1'b1;
            end
            if (i_psel && i_penable && i_pready && i_paddr[PADDR_W-1:2] == REG_GAIN) begin
                if (i_pwrite) begin
                    gain_q = i_pwdata[GAIN_W-1:0];
                end else if (i_prdata !== PDATA_W'(gain_q)) begin
                    $display("%0t: gain readback mismatch, expected %0d, got %0d",
                             $time, gain_q, i_prdata);
                    o_fail_count++;
                end
            end
        end
        o_pending = freq_due.size();
    end

endmodule

[test/tb_quadrature_fm_discriminator.sv]
// Testbench top for quadrature_fm_discriminator: reset, sample stimulus, gain writes, verdict.
// Depends on qfd_pkg, the block's RTL and qfd_freq_checker.
`timescale 1ns / 1ps

module tb_quadrature_fm_discriminator;
    import qfd_pkg::*;

    localparam int N_PHASES        = 8;
    localparam int ITEMS_PER_PHASE = 172;
    localparam int PRESSURE_PHASE  = 3;
    localparam int HOLD_CYCLES     = 400;
    localparam int DRAIN_CYCLES    = 60;
    localparam int WATCHDOG_LIMIT  = 2000;

    localparam logic [PADDR_W-1:0] GAIN_ADDR = {REG_GAIN, 2'b00};
    localparam logic [FIELD_W-1:0] EXTREME_VALS [5] = '{16'h7FFF, 16'h8000, 16'h0000,
                                                       16'hFFFF, 16'h0001};

    typedef enum {SHAPE_NOISE, SHAPE_TONE, SHAPE_TINY, SHAPE_EXTREME} sample_shape_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [2*FIELD_W-1:0]  s_axis_tdata;    // [15:0] in_i, [31:16] in_q
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [FIELD_W-1:0]    m_axis_tdata;    // [15:0] freq
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_W-1:0]    paddr;
    logic [PDATA_W-1:0]    pwdata;
    logic [PDATA_W-1:0]    prdata;
    logic                  pready;

    int   fail_count;
    int   pending;
    logic no_idle;
    logic hold_req;
    real  tone_ph;
    real  tone_step;
    real  tone_amp;

    quadrature_fm_discriminator u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    qfd_freq_checker u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_prdata     (prdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned idle_draw();
        return no_idle ? 0 : $urandom_range(0, 6);
    endfunction

    task automatic send_sample(input logic signed [FIELD_W-1:0] si,
                               input logic signed [FIELD_W-1:0] sq);
        int unsigned gap;
        gap = idle_draw();
        @(negedge i_clk);
        if (gap != 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata = {sq, si};
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic apb_transfer(input logic wr, input logic [PDATA_W-1:0] data);
        @(negedge i_clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = wr;
        paddr = GAIN_ADDR;
        pwdata = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    // receiver: random stalls per result, plus one long hold-off on request
    initial begin
        int unsigned gap;
        m_axis_tready = 1'b0;
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                @(negedge i_clk);
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            gap = idle_draw();
            @(negedge i_clk);
            if (gap != 0) begin
                m_axis_tready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready = 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (psel && penable && pready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("tb_quadrature_fm_discriminator NOT OK");
        $finish;
    end

    initial begin
        int unsigned          run_left;
        sample_shape_t        shape;
        logic signed [15:0]   si;
        logic signed [15:0]   sq;
        logic [GAIN_W-1:0]    g;

        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        no_idle = 1'b0;
        hold_req = 1'b0;
        tone_ph = 0.0;
        tone_step = 0.0;
        tone_amp = 0.0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed, at the reset gain; the first sample only primes
        send_sample(16'sh7FFF, 16'sh8000);
        send_sample(16'sh8000, 16'sh8000);
        send_sample(16'sd0, 16'sd0);            // zero product
        send_sample(16'sd0, 16'sd0);
        send_sample(16'sh7FFF, 16'sh7FFF);
        send_sample(16'sh8000, 16'sh7FFF);
        send_sample(16'sh8000, 16'sh8000);
        send_sample(16'sd100, 16'sd0);
        send_sample(16'sd100, 16'sd100);        // equal magnitudes
        send_sample(-16'sd100, 16'sd100);       // quarter turn
        send_sample(16'sd100, 16'sd0);
        send_sample(-16'sd100, 16'sd0);         // half turn
        send_sample(16'sd100, 16'sd0);
        send_sample(16'sd0, -16'sd100);         // negative quarter turn
        send_sample(16'sd3, -16'sd4);
        send_sample(-16'sd4, 16'sd3);
        send_sample(16'sd1, 16'sd1);
        send_sample(-16'sd1, -16'sd1);
        send_sample(16'sh7FFF, 16'sd0);
        send_sample(16'sd0, 16'sh7FFF);
        send_sample(-16'sh7FFF, 16'sd1);
        settle();

        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: g = 16'd0;
                1: g = 16'hFFFF;
                2: g = 16'd1;
                3: g = 16'd384;
                5: g = GAIN_RESET;
                6: g = 16'd4096;
                default: g = GAIN_W'($urandom);
            endcase
            apb_transfer(1'b1, PDATA_W'(g));
            apb_transfer(1'b0, '0);
            if (ph == PRESSURE_PHASE)
                hold_req = 1'b1;
            run_left = 0;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (run_left == 0) begin
                    run_left = $urandom_range(10, 60);
                    shape = sample_shape_t'($urandom_range(0, 3));
                    no_idle = ($urandom_range(0, 3) == 0) || (ph == PRESSURE_PHASE);
                    tone_amp = real'($urandom_range(1, 32767) >> $urandom_range(0, 14));
                    tone_step = (real'($urandom_range(0, 2000)) - 1000.0) * 0.0031415926;
                end
                run_left--;
                case (shape)
                    SHAPE_TONE: begin
                        tone_ph = tone_ph + tone_step;
                        si = 16'($rtoi(tone_amp * $cos(tone_ph)));
                        sq = 16'($rtoi(tone_amp * $sin(tone_ph)));
                    end
                    SHAPE_TINY: begin
                        si = 16'(int'($urandom_range(0, 8)) - 4);
                        sq = 16'(int'($urandom_range(0, 8)) - 4);
                    end
                    SHAPE_EXTREME: begin
                        si = EXTREME_VALS[$urandom_range(0, 4)];
                        sq = EXTREME_VALS[$urandom_range(0, 4)];
                    end
                    default: {si, sq} = $urandom;
                endcase
                send_sample(si, sq);
            end
            settle();
        end

        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("tb_quadrature_fm_discriminator OK");
        else
            $display("tb_quadrature_fm_discriminator NOT OK");
        $finish;
    end

endmodule
